@@ src/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/mbe_pkg.sv @@
package mbe_pkg;

   localparam int MAX_DIM   = 1024;
   localparam int FRAC_BITS = 28;

   localparam int CFG_W     = 32;
   localparam int CFG_FRAC  = 28;
   localparam int WORK_W    = FRAC_BITS + 4;
   localparam int OPND_W    = (WORK_W > CFG_W) ? WORK_W : CFG_W;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int PIX_W     = 10;
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int CNT_W     = 16;
   localparam int BRIGHT_W  = 8;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_ORIGIN = 3'd0,
      CSR_X_STEP   = 3'd1,
      CSR_Y_ORIGIN = 3'd2,
      CSR_Y_STEP   = 3'd3,
      CSR_LIMIT    = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_HOLD      = 3'd0,
      OP_MUL_COORD = 3'd1,
      OP_FORM_C    = 3'd2,
      OP_MUL_Z     = 3'd3,
      OP_UPDATE_Z  = 3'd4
   } core_op_type;

   typedef struct packed {
      core_op_type op;
   } core_ctrl_type;

   typedef struct packed {
      logic escape;
   } core_status_type;

endpackage

@@ src/mbe_core.sv @@
module mbe_core (
   input  logic                           clock,
   input  mbe_pkg::core_ctrl_type         ctrl,
   input  logic [mbe_pkg::IDX_W-1:0]      col_idx,
   input  logic [mbe_pkg::IDX_W-1:0]      row_idx,
   input  logic signed [mbe_pkg::CFG_W-1:0] x_origin,
   input  logic signed [mbe_pkg::CFG_W-1:0] x_step,
   input  logic signed [mbe_pkg::CFG_W-1:0] y_origin,
   input  logic signed [mbe_pkg::CFG_W-1:0] y_step,
   output mbe_pkg::core_status_type       status
);
   import mbe_pkg::*;

   localparam int SW = PROD_W + 1;
   localparam int UP = (FRAC_BITS >= CFG_FRAC) ? FRAC_BITS - CFG_FRAC : 0;
   localparam int DN = (FRAC_BITS < CFG_FRAC) ? CFG_FRAC - FRAC_BITS : 0;
   localparam int TW = CFG_W + UP;
   localparam logic signed [WORK_W:0] FOUR = (WORK_W + 1)'(1) <<< (FRAC_BITS + 2);

   function automatic logic signed [WORK_W-1:0] sat_work(input logic signed [SW-1:0] v);
      logic [SW-WORK_W:0] top;
      top = v[SW-1:WORK_W-1];
      if ((&top) || !(|top)) begin
         return v[WORK_W-1:0];
      end
      return {v[SW-1], {(WORK_W-1){~v[SW-1]}}};
   endfunction

   function automatic logic signed [CFG_W-1:0] sat_cfg(input logic signed [SW-1:0] v);
      logic [SW-CFG_W:0] top;
      top = v[SW-1:CFG_W-1];
      if ((&top) || !(|top)) begin
         return v[CFG_W-1:0];
      end
      return {v[SW-1], {(CFG_W-1){~v[SW-1]}}};
   endfunction

   // Move Q4.28 to the working format, flooring when bits drop off.
   function automatic logic signed [WORK_W-1:0] to_work(input logic signed [CFG_W-1:0] v);
      logic signed [TW-1:0] t;
      t = TW'(v) <<< UP;
      t = t >>> DN;
      return t[WORK_W-1:0];
   endfunction

   logic signed [OPND_W-1:0] opnd_a [3];
   logic signed [OPND_W-1:0] opnd_b [3];
   logic signed [PROD_W-1:0] prod_ff [3];

   logic signed [WORK_W-1:0] zr_ff, zr_in;
   logic signed [WORK_W-1:0] zi_ff, zi_in;
   logic signed [WORK_W-1:0] cr_ff, cr_in;
   logic signed [WORK_W-1:0] ci_ff, ci_in;

   logic signed [WORK_W-1:0] zr2, zi2, zri;
   logic signed [WORK_W:0]   sq_sum;
   logic                     escape;

   always_comb begin
      opnd_a[2] = OPND_W'(zr_ff);
      opnd_b[2] = OPND_W'(zi_ff);
      if (ctrl.op == OP_MUL_COORD) begin
         opnd_a[0] = OPND_W'(x_step);
         opnd_b[0] = $signed(OPND_W'({1'b0, col_idx}));
         opnd_a[1] = OPND_W'(y_step);
         opnd_b[1] = $signed(OPND_W'({1'b0, row_idx}));
      end else begin
         opnd_a[0] = OPND_W'(zr_ff);
         opnd_b[0] = OPND_W'(zr_ff);
         opnd_a[1] = OPND_W'(zi_ff);
         opnd_b[1] = OPND_W'(zi_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == OP_MUL_COORD || ctrl.op == OP_MUL_Z) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= opnd_a[i] * opnd_b[i];
         end
      end
   end

   assign zr2    = sat_work(SW'(prod_ff[0] >>> FRAC_BITS));
   assign zi2    = sat_work(SW'(prod_ff[1] >>> FRAC_BITS));
   assign zri    = sat_work(SW'(prod_ff[2] >>> FRAC_BITS));
   assign sq_sum = (WORK_W + 1)'(zr2) + (WORK_W + 1)'(zi2);
   assign escape = (sq_sum >= FOUR);

   always_comb begin
      zr_in = zr_ff;
      zi_in = zi_ff;
      cr_in = cr_ff;
      ci_in = ci_ff;
      case (ctrl.op)
         OP_FORM_C: begin
            cr_in = to_work(sat_cfg(SW'(prod_ff[0]) + SW'(x_origin)));
            ci_in = to_work(sat_cfg(SW'(prod_ff[1]) + SW'(y_origin)));
            zr_in = '0;
            zi_in = '0;
         end
         OP_UPDATE_Z: begin
            if (!escape) begin
               zr_in = sat_work(SW'(zr2) - SW'(zi2) + SW'(cr_ff));
               zi_in = sat_work((SW'(zri) <<< 1) + SW'(ci_ff));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      zr_ff <= zr_in;
      zi_ff <= zi_in;
      cr_ff <= cr_in;
      ci_ff <= ci_in;
   end

   assign status.escape = escape;

endmodule

@@ src/mbe_div.sv @@
module mbe_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mbe_pkg::CNT_W-1:0]     count,
   input  logic [mbe_pkg::CNT_W-1:0]     limit,
   output logic                          done,
   output logic [mbe_pkg::BRIGHT_W-1:0]  quotient
);
   import mbe_pkg::*;

   localparam int NUM_W  = CNT_W + BRIGHT_W;
   localparam int STEP_W = $clog2(BRIGHT_W);

   logic [NUM_W-1:0]    rem_ff, rem_in;
   logic [BRIGHT_W-1:0] q_ff, q_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [NUM_W-1:0]    trial;

   assign trial = NUM_W'(limit) << step_ff;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // 255 * count as (count << 8) - count
         rem_in  = (NUM_W'(count) << BRIGHT_W) - NUM_W'(count);
         q_in    = '0;
         step_in = STEP_W'(BRIGHT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in        = rem_ff - trial;
            q_in[step_ff] = 1'b1;
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   // zero limit gives zero brightness
   assign quotient = (limit == '0) ? '0 : q_ff;

endmodule

@@ src/mandelbrot_escape_time.sv @@
// The iteration loop ends when the point escapes or when its count reaches the limit; a zero
// limit skips the loop. Each iteration steps through two states of the shared multiplier unit:
// multiply (ST_SQ_MUL) and update (ST_SQ_UPD). Before the loop ST_COORD_MUL and ST_FORM_C set
// up the point; after it the bit-serial divider runs in ST_DIV and ST_OUT loads the result.
// One pixel at a time: req_stall stays high until the result is registered. Reset idles the
// sequencer, drops rsp_valid, loads csr defaults.
module mandelbrot_escape_time (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mbe_pkg::PIX_W-1:0]           req_pixel_column,
   input  logic [mbe_pkg::PIX_W-1:0]           req_pixel_row,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mbe_pkg::BRIGHT_W-1:0]        rsp_brightness,
   output logic [mbe_pkg::CNT_W-1:0]           rsp_escape_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mbe_pkg::CFG_W-1:0]           csr_wdata
);
   import mbe_pkg::*;

   `include "assert_macros.svh"

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_COORD_MUL = 7'b0000010,
      ST_FORM_C    = 7'b0000100,
      ST_SQ_MUL    = 7'b0001000,
      ST_SQ_UPD    = 7'b0010000,
      ST_DIV       = 7'b0100000,
      ST_OUT       = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [CFG_W-1:0] x_origin_ff, x_step_ff, y_origin_ff, y_step_ff;
   logic [CNT_W-1:0]        limit_ff;

   logic [IDX_W-1:0]    col_ff, col_in;
   logic [IDX_W-1:0]    row_ff, row_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BRIGHT_W-1:0] rsp_brightness_ff;
   logic [CNT_W-1:0]    rsp_escape_count_ff;

   core_ctrl_type   core_ctrl;
   core_status_type core_status;
   logic            div_start;
   logic            div_done;
   logic [BRIGHT_W-1:0] div_quotient;
   logic            req_xfer;
   logic            rsp_load;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= -32'sd536870912;
         x_step_ff   <= 32'sd1048576;
         y_origin_ff <= -32'sd268435456;
         y_step_ff   <= 32'sd1048576;
         limit_ff    <= 16'd256;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_X_ORIGIN: x_origin_ff <= csr_wdata;
            CSR_X_STEP:   x_step_ff   <= csr_wdata;
            CSR_Y_ORIGIN: y_origin_ff <= csr_wdata;
            CSR_Y_STEP:   y_step_ff   <= csr_wdata;
            CSR_LIMIT:    limit_ff    <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      count_in      = count_ff;
      div_start     = 1'b0;
      core_ctrl.op  = OP_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               col_in   = (int'(req_pixel_column) >= MAX_DIM) ? IDX_W'(MAX_DIM - 1)
                                                              : IDX_W'(req_pixel_column);
               row_in   = (int'(req_pixel_row) >= MAX_DIM) ? IDX_W'(MAX_DIM - 1)
                                                           : IDX_W'(req_pixel_row);
               state_in = ST_COORD_MUL;
            end
         end
         ST_COORD_MUL: begin
            core_ctrl.op = OP_MUL_COORD;
            state_in     = ST_FORM_C;
         end
         ST_FORM_C: begin
            core_ctrl.op = OP_FORM_C;
            count_in     = '0;
            if (limit_ff == '0) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in  = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            core_ctrl.op = OP_MUL_Z;
            state_in     = ST_SQ_UPD;
         end
         ST_SQ_UPD: begin
            core_ctrl.op = OP_UPDATE_Z;
            if (core_status.escape) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               count_in = count_ff + 1'b1;
               if (count_in == limit_ff) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in  = ST_SQ_MUL;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold the result until the consumer takes it
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff   <= col_in;
      row_ff   <= row_in;
      count_ff <= count_in;
      if (rsp_load) begin
         rsp_brightness_ff   <= div_quotient;
         rsp_escape_count_ff <= count_ff;
      end
   end

   mbe_core u_core (
      .clock    (clock),
      .ctrl     (core_ctrl),
      .col_idx  (col_ff),
      .row_idx  (row_ff),
      .x_origin (x_origin_ff),
      .x_step   (x_step_ff),
      .y_origin (y_origin_ff),
      .y_step   (y_step_ff),
      .status   (core_status)
   );

   mbe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .count    (count_in),
      .limit    (limit_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_brightness   = rsp_brightness_ff;
   assign rsp_escape_count = rsp_escape_count_ff;

   `ASSERT_IMPLY(a_div_done_in_div, clock, reset, div_done, state_ff == ST_DIV)
   `ASSERT_IMPLY(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_OUT))
   `ASSERT_NEXT(a_count_cleared, clock, reset, state_ff == ST_FORM_C, count_ff == '0)

endmodule

@@ sim/tb_top.sv @@
module tb_top;
   import mbe_pkg::*;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [BRIGHT_W-1:0] brightness;
      logic [CNT_W-1:0]    escape_count;
   } pixel_result_type;

   localparam int HALF_PERIOD = 4;
   localparam int FULL_SCALE  = 255;
   localparam int ONE_Q       = 1 << CFG_FRAC;
   localparam int REG_MAX     = 2147483647;
   localparam int REG_MIN     = -REG_MAX - 1;
   localparam int LIMIT_MAX   = (1 << CNT_W) - 1;

   localparam wide_type WORK_HI  = (wide_type'(1) <<< (FRAC_BITS + 3)) - wide_type'(1);
   localparam wide_type WORK_LO  = -WORK_HI - wide_type'(1);
   localparam wide_type Q28_HI   = (wide_type'(1) <<< (CFG_W - 1)) - wide_type'(1);
   localparam wide_type Q28_LO   = -Q28_HI - wide_type'(1);
   localparam wide_type RADIUS_SQ = wide_type'(1) <<< (FRAC_BITS + 2);
   localparam int SHIFT_UP    = (FRAC_BITS >= CFG_FRAC) ? FRAC_BITS - CFG_FRAC : 0;
   localparam int SHIFT_DN    = (FRAC_BITS < CFG_FRAC) ? CFG_FRAC - FRAC_BITS : 0;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel_column = '0;
   logic [PIX_W-1:0]     req_pixel_row = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BRIGHT_W-1:0]  rsp_brightness;
   logic [CNT_W-1:0]     rsp_escape_count;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // viewport as the block should currently hold it
   logic signed [CFG_W-1:0] view_x_origin;
   logic signed [CFG_W-1:0] view_x_step;
   logic signed [CFG_W-1:0] view_y_origin;
   logic signed [CFG_W-1:0] view_y_step;
   logic [CNT_W-1:0]        view_limit;

   pixel_result_type pending_pixels[$];
   int            mismatches = 0;
   int            sender_idle_pct = 0;
   int            stall_pct = 0;

   mandelbrot_escape_time dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_column (req_pixel_column),
      .req_pixel_row    (req_pixel_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_brightness   (rsp_brightness),
      .rsp_escape_count (rsp_escape_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic void load_defaults();
      view_x_origin = -2 * ONE_Q;
      view_x_step   = ONE_Q >>> 8;
      view_y_origin = -ONE_Q;
      view_y_step   = ONE_Q >>> 8;
      view_limit    = CNT_W'(256);
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
         CSR_X_ORIGIN: view_x_origin = data;
         CSR_X_STEP:   view_x_step = data;
         CSR_Y_ORIGIN: view_y_origin = data;
         CSR_Y_STEP:   view_y_step = data;
         CSR_LIMIT:    view_limit = data[CNT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic wide_type saturate(wide_type v, wide_type lo, wide_type hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // exact product, floor to the working format, clamp
   function automatic wide_type mul_work(wide_type a, wide_type b);
      wide_type p;
      p = (a * b) >>> FRAC_BITS;
      return saturate(p, WORK_LO, WORK_HI);
   endfunction

   function automatic wide_type point_axis(logic signed [CFG_W-1:0] origin,
                                           logic signed [CFG_W-1:0] step,
                                           logic [PIX_W-1:0] idx);
      wide_type index;
      wide_type v;
      index = wide_type'({1'b0, idx});
      if (index >= MAX_DIM) index = wide_type'(MAX_DIM - 1);
      v = wide_type'(origin) + index * wide_type'(step);
      v = saturate(v, Q28_LO, Q28_HI);
      v = (v <<< SHIFT_UP) >>> SHIFT_DN;
      return saturate(v, WORK_LO, WORK_HI);
   endfunction

   function automatic pixel_result_type escape_time(logic [PIX_W-1:0] col,
                                                    logic [PIX_W-1:0] row);
      wide_type cr, ci, zr, zi, zr2, zi2, zri;
      int count;
      pixel_result_type r;
      cr = point_axis(view_x_origin, view_x_step, col);
      ci = point_axis(view_y_origin, view_y_step, row);
      zr = 0;
      zi = 0;
      count = 0;
      while (count < int'(view_limit)) begin
         zr2 = mul_work(zr, zr);
         zi2 = mul_work(zi, zi);
         if (zr2 + zi2 >= RADIUS_SQ) break;
         zri = mul_work(zr, zi);
         zr = saturate(zr2 - zi2 + cr, WORK_LO, WORK_HI);
         zi = saturate(zri + zri + ci, WORK_LO, WORK_HI);
         count++;
      end
      r.escape_count = count[CNT_W-1:0];
      r.brightness = (view_limit == 0) ? '0 :
                     BRIGHT_W'((FULL_SCALE * count) / int'(view_limit));
      return r;
   endfunction

   // called and returns at a falling edge; valid stays high into the next item
   task automatic send_pixel(input int col, input int row);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_column <= PIX_W'(col);
      req_pixel_row <= PIX_W'(row);
      do @(posedge clock); while (req_stall);
      pending_pixels.push_back(escape_time(PIX_W'(col), PIX_W'(row)));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_view(input int x0, input int dx, input int y0, input int dy,
                           input int lim);
      write_reg(CSR_X_ORIGIN, x0);
      write_reg(CSR_X_STEP, dx);
      write_reg(CSR_Y_ORIGIN, y0);
      write_reg(CSR_Y_STEP, dy);
      write_reg(CSR_LIMIT, lim);
   endtask

   task automatic test_default_view();
      send_pixel(0, 0);
      send_pixel(MAX_DIM - 1, MAX_DIM - 1);
      send_pixel(MAX_DIM / 2, MAX_DIM / 4);
      send_pixel(0, MAX_DIM - 1);
      send_pixel(MAX_DIM - 1, 0);
      send_pixel(341, 682);
      wait_idle();
   endtask

   task automatic test_limit_edges();
      write_reg(CSR_LIMIT, 0);
      send_pixel(MAX_DIM / 2, MAX_DIM / 4);
      send_pixel(0, 0);
      wait_idle();
      write_reg(CSR_LIMIT, 1);
      send_pixel(MAX_DIM / 2, MAX_DIM / 4);
      send_pixel(0, 0);
      wait_idle();
      write_reg(CSR_LIMIT, LIMIT_MAX);
      send_pixel(MAX_DIM / 2, MAX_DIM / 4);
      send_pixel(MAX_DIM - 1, MAX_DIM - 1);
      wait_idle();
      write_reg(CSR_LIMIT, FULL_SCALE);
      send_pixel(400, 300);
      wait_idle();
   endtask

   task automatic test_saturation();
      // point clamps to the corners of the format, squares clamp too
      set_view(REG_MAX, REG_MAX, REG_MIN, REG_MIN, 16);
      send_pixel(0, 0);
      send_pixel(MAX_DIM - 1, MAX_DIM - 1);
      send_pixel(1, 1);
      wait_idle();
      set_view(REG_MIN, REG_MAX, REG_MAX, REG_MIN, 16);
      send_pixel(1, 1);
      send_pixel(MAX_DIM - 1, 2);
      wait_idle();
      // c = -2 lands exactly on the escape radius
      set_view(-2 * ONE_Q, 0, 0, 0, 16);
      send_pixel(5, 5);
      wait_idle();
      set_view(ONE_Q / 4, 0, 0, 0, 64);
      send_pixel(0, 0);
      wait_idle();
      set_view(ONE_Q, -(ONE_Q >>> 8), ONE_Q, -(ONE_Q >>> 8), 32);
      send_pixel(MAX_DIM - 1, 100);
      send_pixel(700, MAX_DIM / 4);
      wait_idle();
   endtask

   task automatic test_unknown_index();
      set_view(-2 * ONE_Q, ONE_Q >>> 8, -ONE_Q, ONE_Q >>> 8, 20);
      for (int k = int'(CSR_LIMIT) + 1; k < (1 << CSR_IDX_W); k++)
         write_reg(CSR_IDX_W'(k), $urandom);
      send_pixel(MAX_DIM / 2, MAX_DIM / 4);
      send_pixel(100, 200);
      wait_idle();
   endtask

   task automatic test_random_frames();
      int sender_mix[4] = '{0, 56, 0, 24};
      int stall_mix[4]  = '{0, 0, 56, 24};
      int w, h, span_x, span_y, x0, dx, y0, dy, lim, pick, n;
      bool_loop: for (int mode = 0; mode < 4; mode++) begin
         sender_idle_pct = sender_mix[mode];
         stall_pct = stall_mix[mode];
         for (int v = 0; v < 6; v++) begin
            wait_idle();
            pick = $urandom_range(9);
            w = $urandom_range(2, MAX_DIM);
            h = $urandom_range(2, MAX_DIM);
            if (pick <= 7) begin
               // frame over the interesting part of the plane
               span_x = $urandom_range(ONE_Q / 64, 3 * ONE_Q);
               span_y = $urandom_range(ONE_Q / 64, 2 * ONE_Q);
               x0 = int'($urandom_range(0, 3 * ONE_Q)) - 5 * ONE_Q / 2;
               y0 = int'($urandom_range(0, 2 * ONE_Q)) - 3 * ONE_Q / 2;
               dx = span_x / (w - 1);
               dy = span_y / (h - 1);
               if ($urandom_range(3) == 0) begin
                  x0 = x0 + span_x;
                  dx = -dx;
               end
               if ($urandom_range(3) == 0) begin
                  y0 = y0 + span_y;
                  dy = -dy;
               end
            end else begin
               x0 = $urandom;
               dx = $urandom;
               y0 = $urandom;
               dy = $urandom;
               w = MAX_DIM;
               h = MAX_DIM;
            end
            pick = $urandom_range(19);
            if (pick <= 15) lim = $urandom_range(1, 48);
            else if (pick <= 17) lim = $urandom_range(49, 300);
            else if (pick == 18) lim = $urandom_range(0, 2);
            else lim = $urandom_range(301, 1200);
            n = (lim > 300) ? 6 : ((lim > 48) ? 30 : 92);
            set_view(x0, dx, y0, dy, lim);
            for (int i = 0; i < n; i++) begin
               // hold off until the block has drained, mid-frame
               if (v == 0 && i == n / 2) wait_idle();
               send_pixel(($urandom_range(9) == 0) ? $urandom_range(MAX_DIM - 1) :
                          $urandom_range(w - 1),
                          ($urandom_range(9) == 0) ? $urandom_range(MAX_DIM - 1) :
                          $urandom_range(h - 1));
            end
         end
      end
      wait_idle();
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: brightness %0d count %0d",
                        rsp_brightness, rsp_escape_count);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_brightness !== want.brightness ||
                rsp_escape_count !== want.escape_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: brightness exp %0d got %0d, count exp %0d got %0d",
                           want.brightness, rsp_brightness,
                           want.escape_count, rsp_escape_count);
            end
         end
      end
   end

   initial begin
      load_defaults();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_view();
      test_limit_edges();
      test_saturation();
      test_unknown_index();
      test_random_frames();
      repeat (30) @(negedge clock);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/mbe_pkg.sv
src/mbe_core.sv
src/mbe_div.sv
src/mandelbrot_escape_time.sv
sim/tb_top.sv
